>>> design/scta_pkg.sv
// ----------------------------------------------------------------------------
// scta_pkg - shared constants for the scan-code translator
// Scan-code set 1 key codes, prefix byte and the key lookup function.
// ----------------------------------------------------------------------------
package scta_pkg;

  localparam int unsigned SCAN_W = 8;
  localparam int unsigned CODE_W = 7;
  localparam int unsigned CHAR_W = 7;

  localparam logic [SCAN_W-1:0] PREFIX_BYTE  = 8'hE0;
  localparam logic [CODE_W-1:0] CODE_CTRL    = 7'h1D;
  localparam logic [CODE_W-1:0] CODE_SHIFT_L = 7'h2A;
  localparam logic [CODE_W-1:0] CODE_SHIFT_R = 7'h36;
  localparam logic [CODE_W-1:0] CODE_ALT     = 7'h38;
  localparam logic [CODE_W-1:0] CODE_CAPS    = 7'h3A;

  // Modifier state carried between items
  typedef struct packed {
    logic ctrl;
    logic shift;
    logic alt;
    logic caps;
  } mod_state_t;

  // Return {shifted, plain} ASCII pair; zero for keys with no character
  function automatic logic [2*CHAR_W-1:0] key_pair(input logic [CODE_W-1:0] code);
    logic [2*CHAR_W-1:0] pair;
    case (code)
      7'h01: pair = {7'h1B, 7'h1B};
      7'h02: pair = {7'h21, 7'h31};
      7'h03: pair = {7'h40, 7'h32};
      7'h04: pair = {7'h23, 7'h33};
      7'h05: pair = {7'h24, 7'h34};
      7'h06: pair = {7'h25, 7'h35};
      7'h07: pair = {7'h5E, 7'h36};
      7'h08: pair = {7'h26, 7'h37};
      7'h09: pair = {7'h2A, 7'h38};
      7'h0A: pair = {7'h28, 7'h39};
      7'h0B: pair = {7'h29, 7'h30};
      7'h0C: pair = {7'h5F, 7'h2D};
      7'h0D: pair = {7'h2B, 7'h3D};
      7'h0E: pair = {7'h08, 7'h08};
      7'h0F: pair = {7'h09, 7'h09};
      7'h10: pair = {7'h51, 7'h71};
      7'h11: pair = {7'h57, 7'h77};
      7'h12: pair = {7'h45, 7'h65};
      7'h13: pair = {7'h52, 7'h72};
      7'h14: pair = {7'h54, 7'h74};
      7'h15: pair = {7'h59, 7'h79};
      7'h16: pair = {7'h55, 7'h75};
      7'h17: pair = {7'h49, 7'h69};
      7'h18: pair = {7'h4F, 7'h6F};
      7'h19: pair = {7'h50, 7'h70};
      7'h1A: pair = {7'h7B, 7'h5B};
      7'h1B: pair = {7'h7D, 7'h5D};
      7'h1C: pair = {7'h0D, 7'h0D};
      7'h1E: pair = {7'h41, 7'h61};
      7'h1F: pair = {7'h53, 7'h73};
      7'h20: pair = {7'h44, 7'h64};
      7'h21: pair = {7'h46, 7'h66};
      7'h22: pair = {7'h47, 7'h67};
      7'h23: pair = {7'h48, 7'h68};
      7'h24: pair = {7'h4A, 7'h6A};
      7'h25: pair = {7'h4B, 7'h6B};
      7'h26: pair = {7'h4C, 7'h6C};
      7'h27: pair = {7'h3A, 7'h3B};
      7'h28: pair = {7'h22, 7'h27};
      7'h29: pair = {7'h7E, 7'h60};
      7'h2B: pair = {7'h7C, 7'h5C};
      7'h2C: pair = {7'h5A, 7'h7A};
      7'h2D: pair = {7'h58, 7'h78};
      7'h2E: pair = {7'h43, 7'h63};
      7'h2F: pair = {7'h56, 7'h76};
      7'h30: pair = {7'h42, 7'h62};
      7'h31: pair = {7'h4E, 7'h6E};
      7'h32: pair = {7'h4D, 7'h6D};
      7'h33: pair = {7'h3C, 7'h2C};
      7'h34: pair = {7'h3E, 7'h2E};
      7'h35: pair = {7'h3F, 7'h2F};
      7'h37: pair = {7'h2A, 7'h2A};
      7'h39: pair = {7'h20, 7'h20};
      default: pair = '0;
    endcase
    return pair;
  endfunction

endpackage

>>> design/scta_keymap.sv
// ----------------------------------------------------------------------------
// scta_keymap - key code to ASCII lookup
// Pick the plain or shifted column and read the character for a press code.
// ----------------------------------------------------------------------------
module scta_keymap import scta_pkg::*; (
  input  logic [CODE_W-1:0] code,
  input  mod_state_t        mods,
  output logic [CHAR_W-1:0] char_code
);

  logic                shift_only;
  logic                use_shifted;
  logic [2*CHAR_W-1:0] pair;

  // Digits and punctuation ignore caps lock
  always_comb begin
    shift_only = (code < 7'h0E) || (code == 7'h29) || (code == 7'h1A) ||
                 (code == 7'h1B) || (code == 7'h2B) || (code == 7'h27) ||
                 (code == 7'h28) || ((code >= 7'h33) && (code <= 7'h35));
    use_shifted = shift_only ? mods.shift : (mods.shift ^ mods.caps);
    pair        = key_pair(code);
    char_code   = use_shifted ? pair[2*CHAR_W-1:CHAR_W] : pair[CHAR_W-1:0];
  end

endmodule

>>> design/scancode_to_ascii_translator.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_translator - scan-code set 1 to ASCII
// Two-register pipeline: input register, lookup and modifier update, result.
// ----------------------------------------------------------------------------
// Each input transfer carries one raw scan-code byte and yields exactly one
// result transfer, in order. The byte is captured in an input register; once
// the result register is free it is decoded against the held modifier state
// (ctrl, shift, alt, caps lock and the pending 0xE0 prefix), looked up in the
// built-in key table and loaded into the result register. One byte is taken
// every cycle while the output side keeps up. A stall on the output holds the
// result register and then the input register; a new byte is still taken
// while a finished result waits. The result carries the character (with a
// valid flag in tuser) and the modifier state after the byte. A 0xE0 byte,
// releases, unknown codes, modifier keys and all extended keys give a result
// with char_valid low.
// ----------------------------------------------------------------------------
module scancode_to_ascii_translator import scta_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scan_byte
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] char_code, [7] ctrl_held,
                                  // [8] shift_held, [9] alt_held, [10] caps_on
  output logic [0:0]  out_tuser   // [0] char_valid
);

  // Input register
  logic              in_valid_r;
  logic [SCAN_W-1:0] in_byte_r;

  // Held key state
  logic       prefix_r, prefix_nxt;
  mod_state_t mods_r, mods_nxt;

  // Result register
  logic              out_valid_r;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              char_valid_r, char_valid_nxt;
  mod_state_t        out_mods_r;

  logic              res_ready;
  logic              advance;
  logic [CODE_W-1:0] code;
  logic              release_bit;
  logic [CHAR_W-1:0] table_char;

  // Advance the result stage when it is empty or being taken
  assign res_ready = !out_valid_r || out_tready;
  assign advance   = in_valid_r && res_ready;
  assign in_tready = !in_valid_r || res_ready;

  assign code        = in_byte_r[CODE_W-1:0];
  assign release_bit = in_byte_r[SCAN_W-1];

  scta_keymap u_keymap (
    .code      (code),
    .mods      (mods_r),
    .char_code (table_char)
  );

  // Decode one byte against the held state
  always_comb begin
    prefix_nxt     = prefix_r;
    mods_nxt       = mods_r;
    char_nxt       = '0;
    char_valid_nxt = 1'b0;
    if (in_byte_r == PREFIX_BYTE) begin
      prefix_nxt = 1'b1;
    end else begin
      prefix_nxt = 1'b0;
      if (release_bit) begin
        // Break code: clear the matching held modifier
        if (code == CODE_CTRL) begin
          mods_nxt.ctrl = 1'b0;
        end else if (!prefix_r && (code == CODE_SHIFT_L || code == CODE_SHIFT_R)) begin
          mods_nxt.shift = 1'b0;
        end else if (code == CODE_ALT) begin
          mods_nxt.alt = 1'b0;
        end
      end else if (prefix_r) begin
        // Extended press: only right ctrl and right alt matter
        if (code == CODE_CTRL) begin
          mods_nxt.ctrl = 1'b1;
        end else if (code == CODE_ALT) begin
          mods_nxt.alt = 1'b1;
        end
      end else if (table_char != '0) begin
        char_nxt       = table_char;
        char_valid_nxt = 1'b1;
      end else if (code == CODE_CTRL) begin
        mods_nxt.ctrl = 1'b1;
      end else if (code == CODE_SHIFT_L || code == CODE_SHIFT_R) begin
        mods_nxt.shift = 1'b1;
      end else if (code == CODE_ALT) begin
        mods_nxt.alt = 1'b1;
      end else if (code == CODE_CAPS) begin
        mods_nxt.caps = !mods_r.caps;
      end
    end
  end

  // Input register: capture on every input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // Held state: update as each byte moves into the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= 1'b0;
      mods_r   <= '0;
    end else if (advance) begin
      prefix_r <= prefix_nxt;
      mods_r   <= mods_nxt;
    end
  end

  // Result register: hold while the output is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      char_r       <= char_nxt;
      char_valid_r <= char_valid_nxt;
      out_mods_r   <= mods_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_mods_r.caps, out_mods_r.alt, out_mods_r.shift,
                       out_mods_r.ctrl, char_r};
  assign out_tuser  = char_valid_r;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for scancode_to_ascii_translator
// Drives scan-code set 1 bytes into the input stream and compares each output
// transfer with a local translator model. A short directed table runs first,
// then four random phases with different amounts of idling on each side.
// ----------------------------------------------------------------------------
module tb;
  import scta_pkg::*;

  // Result fields in the order they are compared; the packed layout is the
  // concatenation {tuser[0], tdata[6:0], tdata[7], tdata[8], tdata[9], tdata[10]}
  typedef struct packed {
    logic             valid;
    logic [CHAR_W-1:0] ch;
    logic             ctrl;
    logic             shift;
    logic             alt;
    logic             caps;
  } key_result_t;

  // Directed row: a typed row carries its result inline (modifiers all clear)
  typedef struct packed {
    logic [SCAN_W-1:0] scan;
    logic              typed;
    logic              want_valid;
    logic [CHAR_W-1:0] want_char;
  } stim_row_t;

  localparam int KEY_COUNT   = 59;   // codes 0x00..0x3a have a table entry
  localparam int RANDOM_ITEMS = 175;  // per phase
  localparam int PHASES      = 4;

  // Plain and shifted column of the key table, indexed by scan code
  localparam logic [CHAR_W-1:0] PLAIN_COL [KEY_COUNT] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,  // 0x00
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,  // 0x08
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,  // 0x10
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,  // 0x18
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,  // 0x20
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,  // 0x28
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,  // 0x30
    7'h00, 7'h20, 7'h00                                      // 0x38
  };
  localparam logic [CHAR_W-1:0] SHIFT_COL [KEY_COUNT] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,  // 0x00
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,  // 0x08
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,  // 0x10
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,  // 0x18
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,  // 0x20
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,  // 0x28
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,  // 0x30
    7'h00, 7'h20, 7'h00                                      // 0x38
  };

  // Directed part: reset values, extremes of the byte, prefix handling, modifier
  // presses and releases, caps lock against shift, and ignored extended keys
  localparam stim_row_t DIRECTED [26] = '{
    '{8'h02, 1'b1, 1'b1, 7'h31},                      // '1' right after reset
    '{8'h00, 1'b1, 1'b0, 7'h00},                      // press of code zero
    '{8'h7F, 1'b1, 1'b0, 7'h00},                      // highest press code
    '{8'hFF, 1'b1, 1'b0, 7'h00},                      // highest byte, a release
    '{8'h80, 1'b1, 1'b0, 7'h00},                      // release of code zero
    '{PREFIX_BYTE, 1'b1, 1'b0, 7'h00},                // prefix
    '{PREFIX_BYTE, 1'b1, 1'b0, 7'h00},                // prefix twice in a row
    '{{1'b0, CODE_CTRL}, 1'b0, 1'b0, 7'h00},          // right ctrl press
    '{8'h10, 1'b0, 1'b0, 7'h00},                      // 'q' with ctrl held
    '{{1'b1, CODE_CTRL}, 1'b0, 1'b0, 7'h00},          // ctrl release
    '{{1'b0, CODE_SHIFT_R}, 1'b0, 1'b0, 7'h00},       // right shift press
    '{8'h02, 1'b0, 1'b0, 7'h00},                      // '!' with shift
    '{{1'b0, CODE_CAPS}, 1'b0, 1'b0, 7'h00},          // caps on while shifted
    '{8'h1E, 1'b0, 1'b0, 7'h00},                      // shift and caps cancel
    '{PREFIX_BYTE, 1'b0, 1'b0, 7'h00},
    '{{1'b1, CODE_SHIFT_L}, 1'b0, 1'b0, 7'h00},       // extended shift release
    '{{1'b1, CODE_SHIFT_R}, 1'b0, 1'b0, 7'h00},       // real shift release
    '{8'h1E, 1'b0, 1'b0, 7'h00},                      // 'A' from caps alone
    '{8'h0C, 1'b0, 1'b0, 7'h00},                      // '-' ignores caps
    '{{1'b0, CODE_ALT}, 1'b0, 1'b0, 7'h00},           // left alt press
    '{PREFIX_BYTE, 1'b0, 1'b0, 7'h00},
    '{8'h1C, 1'b0, 1'b0, 7'h00},                      // keypad enter, ignored
    '{{1'b1, CODE_ALT}, 1'b0, 1'b0, 7'h00},           // alt release
    '{{1'b0, CODE_CAPS}, 1'b0, 1'b0, 7'h00},          // caps off
    '{8'h39, 1'b0, 1'b0, 7'h00},                      // space
    '{8'h3B, 1'b0, 1'b0, 7'h00}                       // first code past the table
  };

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [SCAN_W-1:0]   in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [15:0]         out_tdata;
  logic [0:0]          out_tuser;

  // Translator model state
  logic       prefix_seen = 1'b0;
  mod_state_t held        = '0;

  key_result_t pending_chars[$];  // characters still to come out, oldest first
  int          mismatches = 0;
  int          sent_count = 0;
  int          idle_pct   = 0;     // chance per cycle that the sender holds off
  int          stall_pct  = 0;     // chance per cycle that the receiver stalls

  scancode_to_ascii_translator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] scan_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [6:0] char_code, [7] ctrl_held, [8] shift_held,
                               // [9] alt_held, [10] caps_on
    .out_tuser  (out_tuser)    // [0] char_valid
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net: far beyond the slowest legal run at the heaviest idling
  initial begin
    #400000;
    $display("tb NOT OK");
    $finish;
  end

  // Digit and punctuation keys pick their column with shift alone
  function automatic logic is_symbol_key(input logic [CODE_W-1:0] code);
    return code < 7'h0E || code == 7'h1A || code == 7'h1B || code == 7'h27 ||
           code == 7'h28 || code == 7'h29 || code == 7'h2B ||
           (code >= 7'h33 && code <= 7'h35);
  endfunction

  // Advance the model by one scan byte and return the result it produces
  function automatic key_result_t translate_key(input logic [SCAN_W-1:0] scan);
    key_result_t       r;
    logic              ext;
    logic              col;
    logic [CODE_W-1:0] code;
    logic [CHAR_W-1:0] c;
    r = '0;
    if (scan == PREFIX_BYTE) begin
      prefix_seen = 1'b1;
    end else begin
      ext = prefix_seen;
      code = scan[CODE_W-1:0];
      prefix_seen = 1'b0;
      if (scan[7]) begin
        // Break code: only ctrl, shift and alt react; extended shift is fake
        if (code == CODE_CTRL) begin
          held.ctrl = 1'b0;
        end else if (!ext && (code == CODE_SHIFT_L || code == CODE_SHIFT_R)) begin
          held.shift = 1'b0;
        end else if (code == CODE_ALT) begin
          held.alt = 1'b0;
        end
      end else if (ext) begin
        // Extended make code: right ctrl and right alt, everything else dropped
        if (code == CODE_CTRL) begin
          held.ctrl = 1'b1;
        end else if (code == CODE_ALT) begin
          held.alt = 1'b1;
        end
      end else if (code != '0 && int'(code) < KEY_COUNT) begin
        col = is_symbol_key(code) ? held.shift : (held.shift ^ held.caps);
        c = col ? SHIFT_COL[code[5:0]] : PLAIN_COL[code[5:0]];
        if (c != '0) begin
          r.valid = 1'b1;
          r.ch = c;
        end else if (code == CODE_CTRL) begin
          held.ctrl = 1'b1;
        end else if (code == CODE_SHIFT_L || code == CODE_SHIFT_R) begin
          held.shift = 1'b1;
        end else if (code == CODE_ALT) begin
          held.alt = 1'b1;
        end else if (code == CODE_CAPS) begin
          held.caps = ~held.caps;
        end
      end
    end
    r.ctrl  = held.ctrl;
    r.shift = held.shift;
    r.alt   = held.alt;
    r.caps  = held.caps;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got 'h%0h, expected 'h%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one byte, idling first at random; record its result once taken.
  // Valid is lowered only in the idle loop and in drain, so back-to-back
  // transfers never see a lower and a raise in the same step.
  task automatic send_byte(input logic [SCAN_W-1:0] scan, input key_result_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= scan;
    do @(posedge clk); while (!in_tready);
    pending_chars.push_back(want);
    sent_count++;
  endtask

  task automatic send_key(input logic [SCAN_W-1:0] scan);
    send_byte(scan, translate_key(scan));
  endtask

  // Hold the input off until every outstanding result has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // One random keyboard action: mostly real key strokes and modifier use,
  // the rest prefixed bytes and raw noise over the whole byte range
  task automatic send_gesture();
    int                pick;
    logic              ext;
    logic [CODE_W-1:0] code;
    pick = $urandom_range(99);
    ext  = 1'b0;
    code = '0;
    if (pick >= 65) begin
      if (pick < 75) send_key(PREFIX_BYTE);
      send_key(8'($urandom_range(255)));
    end else begin
      if (pick < 40) begin
        code = 7'($urandom_range(8'h39, 1));
      end else if (pick < 58) begin
        case ($urandom_range(6))
          0: code = CODE_CTRL;
          1: begin
            code = CODE_CTRL;
            ext = 1'b1;
          end
          2: code = CODE_SHIFT_L;
          3: code = CODE_SHIFT_R;
          4: code = CODE_ALT;
          5: begin
            code = CODE_ALT;
            ext = 1'b1;
          end
          default: begin
            // fake shift that some keyboards wrap around extended keys
            code = CODE_SHIFT_L;
            ext = 1'b1;
          end
        endcase
      end else begin
        code = CODE_CAPS;
      end
      if (ext) send_key(PREFIX_BYTE);
      send_key({1'b0, code});
      // Release only half the time so modifiers stay held across keys
      if ($urandom_range(1) == 1) begin
        if (ext) send_key(PREFIX_BYTE);
        send_key({1'b1, code});
      end
    end
  endtask

  // Receiver: randomize ready and check every output transfer against the
  // oldest outstanding result, field by field
  always @(posedge clk) begin
    key_result_t got;
    key_result_t want;
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata[6:0], out_tdata[7], out_tdata[8],
             out_tdata[9], out_tdata[10]};
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected result", int'(out_tdata), 0);
      end else begin
        want = pending_chars.pop_front();
        if (got.valid !== want.valid)
          report_mismatch("char_valid", int'(got.valid), int'(want.valid));
        if (got.ch !== want.ch)
          report_mismatch("char_code", int'(got.ch), int'(want.ch));
        if (got.ctrl !== want.ctrl)
          report_mismatch("ctrl_held", int'(got.ctrl), int'(want.ctrl));
        if (got.shift !== want.shift)
          report_mismatch("shift_held", int'(got.shift), int'(want.shift));
        if (got.alt !== want.alt)
          report_mismatch("alt_held", int'(got.alt), int'(want.alt));
        if (got.caps !== want.caps)
          report_mismatch("caps_on", int'(got.caps), int'(want.caps));
      end
    end
  end

  // Stimulus
  initial begin
    key_result_t want;
    int          target;
    int          half;

    // Hold reset low, then release it for good
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: typed rows carry their result, the rest use the model;
    // the model still runs on typed rows to track the key state
    foreach (DIRECTED[i]) begin
      want = translate_key(DIRECTED[i].scan);
      if (DIRECTED[i].typed) begin
        want       = '0;
        want.valid = DIRECTED[i].want_valid;
        want.ch    = DIRECTED[i].want_char;
      end
      send_byte(DIRECTED[i].scan, want);
    end
    drain();

    // Random phases: free flow, slow sender, slow receiver, both slow
    for (int phase = 0; phase < PHASES; phase++) begin
      idle_pct  = (phase == 1) ? 63 : (phase == 3) ? 33 : 0;
      stall_pct = (phase == 2) ? 63 : (phase == 3) ? 33 : 0;
      target = sent_count + RANDOM_ITEMS;
      half   = sent_count + RANDOM_ITEMS / 2;
      while (sent_count < target) begin
        send_gesture();
        // In the slow-receiver phase, pause the sender once mid-phase until the output has caught up
        if (phase == 2 && sent_count >= half && half != 0) begin
          drain();
          half = 0;
        end
      end
      drain();
    end

    // Let the pipeline settle before the verdict
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
